// ----- rtl/core/rsd_pkg.sv -----
// Package for the running standard deviation block.
// Constants, widths and the snapshot type shared by front, queue and back.
package rsd_pkg;

  localparam int MAX_COUNT   = 65536;
  localparam int SAMPLE_BITS = 16;

  localparam int IN_W    = 16;
  localparam int CNT_W   = 17;
  localparam int SUM_W   = 33;
  localparam int SQ_W    = 47;
  localparam int MEAN_W  = 24;
  localparam int STD_W   = 24;
  localparam int MAG_W   = 32;
  localparam int ACC_W   = 64;
  localparam int NSQ_W   = 33;
  localparam int QUO_W   = 47;
  localparam int DEPTH   = 2;

  localparam int MEAN_STEPS = MAG_W + 8;
  localparam int VAR_STEPS  = QUO_W;
  localparam int SQRT_STEPS = STD_W;

  typedef struct packed {
    logic [CNT_W-1:0]        n;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sumsq;
    logic                    sat;
  } snap_t;

endpackage

// ----- rtl/core/rsd_fifo.sv -----
// Two-entry queue of statistic snapshots between front and back.
// Depends on rsd_pkg.
module rsd_fifo import rsd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  snap_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output snap_t pop_data
);

  snap_t      mem_r [DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;

  assign full      = (fill_r == 2'(DEPTH));
  assign not_empty = (fill_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !not_empty))
    else $error("pop from empty queue");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= 2'(DEPTH))
    else $error("queue fill out of range");

endmodule

// ----- rtl/core/rsd_front.sv -----
// Front end: takes sample beats and updates count, sum and sum of squares.
// Depends on rsd_pkg; pushes a snapshot per beat into rsd_fifo.
module rsd_front import rsd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [IN_W-1:0] in_sample,
  input  logic            q_full,
  output logic            q_push,
  output snap_t           q_data
);

  logic [CNT_W-1:0]        count_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]         sumsq_r;

  logic [SAMPLE_BITS-1:0]  raw;
  logic signed [SUM_W-1:0] s_ext;
  logic [SAMPLE_BITS-1:0]  s_mag;
  logic                    can_acc;
  logic [CNT_W-1:0]        count_nxt;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [SQ_W-1:0]         sumsq_nxt;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign raw      = in_sample[SAMPLE_BITS-1:0];
  assign s_ext    = {{(SUM_W-SAMPLE_BITS){raw[SAMPLE_BITS-1]}}, raw};
  assign s_mag    = raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(-raw) : raw;
  assign can_acc  = (count_r < CNT_W'(MAX_COUNT));

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    sumsq_nxt = sumsq_r;
    if (can_acc) begin
      count_nxt = count_r + 1'b1;
      sum_nxt   = sum_r + s_ext;
      sumsq_nxt = sumsq_r + SQ_W'({1'b0, s_mag} * {1'b0, s_mag});
    end
  end

  assign q_data.n     = count_nxt;
  assign q_data.sum   = sum_nxt;
  assign q_data.sumsq = sumsq_nxt;
  assign q_data.sat   = (count_nxt >= CNT_W'(MAX_COUNT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      sumsq_r <= '0;
    end else if (q_push) begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      sumsq_r <= sumsq_nxt;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_COUNT))
    else $error("count above limit");
  a_hold_at_max: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CNT_W'(MAX_COUNT)) |=> (count_r == CNT_W'(MAX_COUNT)) && $stable(sum_r))
    else $error("accumulation past limit");

endmodule

// ----- rtl/core/rsd_back.sv -----
// Back end: sequencer with multiply states, bit-serial divider and
// bit-serial square root; holds the output register. Depends on rsd_pkg.
module rsd_back import rsd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_not_empty,
  input  snap_t                    q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [MEAN_W-1:0] out_mean_q8,
  output logic [STD_W-1:0]         out_std_q8,
  output logic [CNT_W-1:0]         out_sample_count,
  output logic                     out_saturated
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_DIVM, ST_DIVV, ST_SQRT, ST_DONE
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    n_r;
  logic [SQ_W-1:0]     sq_r;
  logic                sat_r;
  logic [MAG_W-1:0]    mag_r;
  logic                neg_r;
  logic [ACC_W-1:0]    acc_r;
  logic [NSQ_W-1:0]    nsq_r;
  logic [NSQ_W-1:0]    d_r;
  logic [NSQ_W:0]      rem_r;
  logic [QUO_W-1:0]    dvd_r;
  logic [QUO_W-1:0]    q_r;
  logic [5:0]          cnt_r;
  logic [MEAN_W-1:0]   mean_r;
  logic [2*STD_W-1:0]  rad_r;
  logic [STD_W+1:0]    srem_r;
  logic [STD_W-1:0]    root_r;
  logic                out_valid_r;
  logic [MEAN_W-1:0]   out_mean_r;
  logic [STD_W-1:0]    out_std_r;
  logic [CNT_W-1:0]    out_cnt_r;
  logic                out_sat_r;

  logic [NSQ_W:0]      rem_sh;
  logic                dv_ge;
  logic [NSQ_W:0]      rem_new;
  logic [QUO_W-1:0]    q_new;
  logic [STD_W+1:0]    srem_sh;
  logic [STD_W+1:0]    trial;
  logic                sq_ge;
  logic [MAG_W:0]      sum_abs;
  logic [MEAN_W-1:0]   mean_mag;

  assign rem_sh   = {rem_r[NSQ_W-1:0], dvd_r[QUO_W-1]};
  assign dv_ge    = (rem_sh >= {1'b0, d_r});
  assign rem_new  = dv_ge ? (rem_sh - {1'b0, d_r}) : rem_sh;
  assign q_new    = {q_r[QUO_W-2:0], dv_ge};
  assign srem_sh  = {srem_r[STD_W-1:0], rad_r[2*STD_W-1 -: 2]};
  assign trial    = {root_r, 2'b01};
  assign sq_ge    = (srem_sh >= trial);
  assign sum_abs  = q_data.sum[SUM_W-1] ? (MAG_W+1)'(-q_data.sum) : (MAG_W+1)'(q_data.sum);
  assign mean_mag = q_new[MEAN_W-1:0] + {{(MEAN_W-1){1'b0}}, (rem_new != '0)};

  assign q_pop            = (state_r == ST_IDLE) && q_not_empty;
  assign out_valid        = out_valid_r;
  assign out_mean_q8      = out_mean_r;
  assign out_std_q8       = out_std_r;
  assign out_sample_count = out_cnt_r;
  assign out_saturated    = out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready && (state_r != ST_DONE)) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (q_not_empty) begin
            n_r     <= q_data.n;
            sq_r    <= q_data.sumsq;
            sat_r   <= q_data.sat;
            mag_r   <= sum_abs[MAG_W-1:0];
            neg_r   <= q_data.sum[SUM_W-1];
            state_r <= ST_MUL0;
          end
        end
        ST_MUL0: begin
          acc_r   <= ACC_W'(n_r * sq_r[23:0]);
          nsq_r   <= NSQ_W'(n_r * n_r);
          state_r <= ST_MUL1;
        end
        ST_MUL1: begin
          acc_r   <= acc_r + (ACC_W'(n_r * sq_r[SQ_W-1:24]) << 24);
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          acc_r   <= acc_r - ACC_W'(mag_r * mag_r);
          d_r     <= NSQ_W'(n_r);
          rem_r   <= '0;
          dvd_r   <= {mag_r, 8'd0, {(QUO_W-MEAN_STEPS){1'b0}}};
          q_r     <= '0;
          cnt_r   <= 6'(MEAN_STEPS - 1);
          state_r <= ST_DIVM;
        end
        ST_DIVM: begin
          rem_r <= rem_new;
          dvd_r <= dvd_r << 1;
          q_r   <= q_new;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == 6'd0) begin
            mean_r  <= neg_r ? MEAN_W'(-mean_mag) : q_new[MEAN_W-1:0];
            rem_r   <= {1'b0, acc_r[ACC_W-1:ACC_W-NSQ_W]};
            dvd_r   <= {acc_r[ACC_W-NSQ_W-1:0], 16'd0};
            d_r     <= nsq_r;
            q_r     <= '0;
            cnt_r   <= 6'(VAR_STEPS - 1);
            state_r <= ST_DIVV;
          end
        end
        ST_DIVV: begin
          rem_r <= rem_new;
          dvd_r <= dvd_r << 1;
          q_r   <= q_new;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == 6'd0) begin
            rad_r   <= {1'b0, q_new};
            srem_r  <= '0;
            root_r  <= '0;
            cnt_r   <= 6'(SQRT_STEPS - 1);
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          srem_r <= sq_ge ? (srem_sh - trial) : srem_sh;
          root_r <= {root_r[STD_W-2:0], sq_ge};
          rad_r  <= rad_r << 2;
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == 6'd0) state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_mean_r  <= mean_r;
            out_std_r   <= root_r;
            out_cnt_r   <= n_r;
            out_sat_r   <= sat_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_MUL0))
    else $error("pop without start");
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVM || state_r == ST_DIVV) |-> (rem_r < {1'b0, d_r}))
    else $error("divider remainder not below divisor");
  a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && (!out_valid_r || out_ready)) |=> out_valid_r)
    else $error("result not presented");

endmodule

// ----- rtl/core/running_standard_deviation_top.sv -----
// Running standard deviation: top level.
// Uses rsd_pkg, rsd_front, rsd_fifo and rsd_back.
//
// Input channel in_valid/in_ready/in_sample: one signed sample per beat.
// Result channel out_valid/out_ready: running mean and population standard
// deviation (both Q8, floored), the sample count and the saturated flag,
// one result beat per input beat, in order.
// The front updates count, sum and sum of squares in the accept cycle and
// queues a snapshot (two entries). The back takes one snapshot at a time:
// the multiply states MUL0, MUL1 and MUL2, a 40-step mean divider, a
// 47-step variance divider and a 24-step square root, then the output
// register.
// Once the count reaches its limit, samples still produce results but are
// not accumulated and saturated is set.
// Reset clears the statistics, the queue and out_valid.
// When the receiver stalls, the result waits in the output register, the
// back waits after its next result and the queue fills; in_ready drops
// once the queue is full.
module running_standard_deviation_top import rsd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [IN_W-1:0]          in_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [MEAN_W-1:0] out_mean_q8,
  output logic [STD_W-1:0]         out_std_q8,
  output logic [CNT_W-1:0]         out_sample_count,
  output logic                     out_saturated
);

  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_not_empty;
  snap_t q_wdata;
  snap_t q_rdata;

  rsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  rsd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_rdata)
  );

  rsd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mean_q8      (out_mean_q8),
    .out_std_q8       (out_std_q8),
    .out_sample_count (out_sample_count),
    .out_saturated    (out_saturated)
  );

endmodule

// ----- dv/tb_running_standard_deviation_top.sv -----
// Testbench for running_standard_deviation_top: directed and random tests.
// Depends on rsd_pkg and the top level; an in-bench model predicts every result beat.
`timescale 1ns / 1ps

module tb_running_standard_deviation_top;
  import rsd_pkg::*;

  typedef struct {
    logic signed [MEAN_W-1:0] mean_q8;
    logic [STD_W-1:0]         std_q8;
    logic [CNT_W-1:0]         sample_count;
    logic                     saturated;
  } stats_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [IN_W-1:0]          in_sample;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [MEAN_W-1:0] out_mean_q8;
  logic [STD_W-1:0]         out_std_q8;
  logic [CNT_W-1:0]         out_sample_count;
  logic                     out_saturated;

  logic [CNT_W-1:0]        acc_count;
  logic signed [SUM_W-1:0] acc_sum;
  logic [SQ_W-1:0]         acc_sumsq;

  stats_t pending_stats[$];
  int     n_errors;
  int     n_sent;
  int     n_checked;
  bit     no_idle;

  running_standard_deviation_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("timeout: sent %0d, checked %0d", n_sent, n_checked);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // update the running statistics with one sample and form the expected beat
  function automatic stats_t accumulate(logic [IN_W-1:0] raw);
    stats_t               r;
    logic signed [63:0]   s;
    logic [63:0]          mag;
    logic [63:0]          n;
    logic signed [63:0]   mean;
    logic [127:0]         num;
    logic [127:0]         quo;
    s = $signed(raw[SAMPLE_BITS-1:0]);
    if (acc_count < MAX_COUNT) begin
      acc_count = acc_count + 1'b1;
      acc_sum   = acc_sum + s;
      acc_sumsq = acc_sumsq + s * s;
    end
    n   = acc_count;
    mag = (acc_sum < 0) ? -64'(acc_sum) : 64'(acc_sum);
    if (acc_sum < 0) mean = -64'(((mag << 8) + n - 1) / n);
    else mean = (mag << 8) / n;
    num = 128'(n) * 128'(acc_sumsq) - 128'(mag) * 128'(mag);
    quo = (num << 16) / (128'(n) * 128'(n));
    r.mean_q8      = mean[MEAN_W-1:0];
    r.std_q8       = STD_W'(int_sqrt(quo[63:0]));
    r.sample_count = acc_count;
    r.saturated    = (acc_count >= MAX_COUNT);
    return r;
  endfunction

  task automatic send_sample(logic [IN_W-1:0] v);
    if (!no_idle && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_stats.insert(pending_stats.size(), accumulate(v));
    n_sent++;
  endtask

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    stats_t e;
    if (rst_n && out_valid && out_ready) begin
      n_checked++;
      if (pending_stats.size() == 0) begin
        $error("result beat with no expectation pending");
        n_errors++;
      end else begin
        e = pending_stats.pop_front();
        if (out_mean_q8 !== e.mean_q8) begin
          $error("mean_q8: expected %0d, got %0d", e.mean_q8, out_mean_q8);
          n_errors++;
        end
        if (out_std_q8 !== e.std_q8) begin
          $error("std_q8: expected %0d, got %0d", e.std_q8, out_std_q8);
          n_errors++;
        end
        if (out_sample_count !== e.sample_count) begin
          $error("sample_count: expected %0d, got %0d", e.sample_count, out_sample_count);
          n_errors++;
        end
        if (out_saturated !== e.saturated) begin
          $error("saturated: expected %0d, got %0d", e.saturated, out_saturated);
          n_errors++;
        end
      end
    end
  end

  task automatic test_directed();
    logic [IN_W-1:0] pts[$];
    pts = '{16'h0000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'hffff, 16'h0001,
            16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h5555,
            16'haaaa, 16'hfffe, 16'h0002, 16'h8001, 16'h7ffe, 16'h0000};
    foreach (pts[i]) send_sample(pts[i]);
  endtask

  task automatic test_random(int items);
    logic [IN_W-1:0] v;
    int run;
    run = 0;
    for (int i = 0; i < items; i++) begin
      no_idle = (i >= items / 2) && (i < items / 2 + 150);
      case ($urandom_range(3))
        0: v = 16'($urandom_range(16'hffff));
        1: v = 16'($signed($urandom_range(64)) - 32);
        2: v = $urandom_range(1) ? 16'(16'h7fff - $urandom_range(3)) :
                                   16'(16'h8000 + $urandom_range(3));
        default: v = 16'($urandom_range(200));
      endcase
      send_sample(v);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_sample <= '0;
    acc_count = '0;
    acc_sum   = '0;
    acc_sumsq = '0;
    n_errors  = 0;
    n_sent    = 0;
    n_checked = 0;
    no_idle   = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(780);
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d samples (full-scale extremes, small and mixed random values);",
             n_sent);
    $display("compared %0d result beats, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0 && pending_stats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/rsd_pkg.sv
rtl/core/rsd_fifo.sv
rtl/core/rsd_front.sv
rtl/core/rsd_back.sv
rtl/core/running_standard_deviation_top.sv
dv/tb_running_standard_deviation_top.sv
